>>> rtl/trapezoidal_pulse_shaper_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the trapezoidal pulse shaper
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_PULSE_SHAPER_ASSERT_SVH
`define TRAPEZOIDAL_PULSE_SHAPER_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define TPS_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tps assertion failed");
// Expression must never be true outside reset
`define TPS_ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tps forbidden condition seen");
`else
`define TPS_ASSERT(name, clk, rst, prop)
`define TPS_ASSERT_NEVER(name, clk, rst, expr)
`endif

`endif

>>> rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// Trapezoidal pulse shaper package
// Register indexes, field widths, reset values and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tps_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLAT_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_RECIP = 2'd2;

  // Register widths and reset values
  localparam int RISE_W  = 10;
  localparam int FLAT_W  = 10;
  localparam int RECIP_W = 17;

  localparam logic [RISE_W-1:0]  RISE_LEN_RST   = 10'd64;
  localparam logic [FLAT_W-1:0]  FLAT_LEN_RST   = 10'd32;
  localparam logic [RECIP_W-1:0] NORM_RECIP_RST = 17'd1024;

  // Result fields
  localparam int SHAPED_W   = 16;
  localparam int SUM_W      = 24;
  localparam int SHAPED_MAX = 32767;
  localparam int SHAPED_MIN = -32768;
  localparam int SUM_MAX    = 8388607;
  localparam int SUM_MIN    = -8388608;

  // Q16 gain: round half up before dropping the fraction
  localparam int FRAC_BITS  = 16;
  localparam int ROUND_HALF = 32768;

  // Number of delayed taps per sample
  localparam int NUM_TAPS = 3;

  // Side information that travels with the tap data
  typedef struct packed {
    logic                start;
    logic [NUM_TAPS-1:0] tap_ok;
  } tps_stage_t;

endpackage

>>> rtl/tps_in_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel that carries one ADC sample and its start flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tps_in_if #(
  parameter int SAMPLE_BITS = 14
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);
endinterface

>>> rtl/tps_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the shaped value and the raw running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tps_out_if
  import tps_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SHAPED_W-1:0] shaped;
  logic signed [SUM_W-1:0]    raw_sum;

  modport source (output valid, output shaped, output raw_sum, input ready);
  modport sink   (input valid, input shaped, input raw_sum, output ready);
endinterface

>>> rtl/tps_tap_ram.sv
// ----------------------------------------------------------------------------
// Tap memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tps_tap_ram #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tps_delay_taps.sv
// ----------------------------------------------------------------------------
// Delay line and tap fetch
// Stores each accepted sample in a ring and fetches the three delayed
// samples at rise, rise+flat and 2*rise+flat, flagging those before start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trapezoidal_pulse_shaper_assert.svh"

module tps_delay_taps
  import tps_pkg::*;
#(
  parameter int MAX_RISE    = 512,
  parameter int MAX_FLAT    = 512,
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [RISE_W-1:0]                    rise_len,
  input  logic [FLAT_W-1:0]                    flat_len,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample,
  input  logic                                 start_req,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        cur,
  output logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps,
  output tps_stage_t                           info
);

  localparam int AW        = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
  localparam int SW        = $clog2(DELAY_DEPTH + 1);
  localparam int KW        = $clog2(MAX_RISE + 1);
  localparam int LW        = (MAX_FLAT > 0) ? $clog2(MAX_FLAT + 1) : 1;
  localparam int MAX_DELAY = 2 * MAX_RISE + MAX_FLAT;
  localparam int DW        = $clog2(MAX_DELAY + 1);
  localparam int CW        = ((DW > AW) ? DW : AW) + 1;

  logic [AW-1:0]                wp;
  logic [AW-1:0]                wp_next;
  logic [SW-1:0]                seen;
  logic [SW-1:0]                seen_eff;
  logic [SW-1:0]                seen_next;
  logic [KW-1:0]                k;
  logic [LW-1:0]                l;
  logic [NUM_TAPS-1:0][DW-1:0]  dly;
  logic [NUM_TAPS-1:0][AW-1:0]  raddr;
  logic [NUM_TAPS-1:0]          tap_ok;
  logic [CW-1:0]                diff;
  logic                         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Clamp rise and flat lengths to the supported range
  always_comb begin
    if (rise_len == '0) begin
      k = KW'(1);
    end else if (32'(rise_len) > MAX_RISE) begin
      k = KW'(MAX_RISE);
    end else begin
      k = KW'(rise_len);
    end
    if (32'(flat_len) > MAX_FLAT) begin
      l = LW'(MAX_FLAT);
    end else begin
      l = LW'(flat_len);
    end
  end

  // Tap delays
  assign dly[0] = DW'(k);
  assign dly[1] = DW'(k) + DW'(l);
  assign dly[2] = DW'(k) + DW'(k) + DW'(l);

  // A start request drops all history before this sample
  assign seen_eff = start_req ? '0 : seen;

  // Tap availability and ring read addresses
  always_comb begin
    diff = '0;
    for (int i = 0; i < NUM_TAPS; i++) begin
      tap_ok[i] = 32'(dly[i]) <= 32'(seen_eff);
      diff      = CW'(wp) - CW'(dly[i]);
      if (CW'(dly[i]) > CW'(wp)) begin
        diff = diff + CW'(DELAY_DEPTH);
      end
      raddr[i]  = AW'(diff);
    end
  end

  // Advance ring pointer and saturating fill count
  assign wp_next   = (32'(wp) == DELAY_DEPTH - 1) ? '0 : wp + AW'(1);
  assign seen_next = (32'(seen_eff) < DELAY_DEPTH) ? seen_eff + SW'(1) : seen_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        wp        <= wp_next;
        seen      <= seen_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the current sample and tap flags next to the fetched taps
  always_ff @(posedge clk) begin
    if (accept) begin
      cur         <= sample;
      info.start  <= start_req;
      info.tap_ok <= tap_ok;
    end
  end

  // One memory copy per tap, all written with the same sample
  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
    tps_tap_ram #(
      .DEPTH  (DELAY_DEPTH),
      .ADDR_W (AW),
      .DATA_W (SAMPLE_BITS)
    ) u_ram (
      .clk   (clk),
      .we    (accept),
      .waddr (wp),
      .wdata (sample),
      .re    (accept),
      .raddr (raddr[g]),
      .rdata (taps[g])
    );
  end

  `TPS_ASSERT_NEVER(a_seen_bound, clk, rst, 32'(seen) > DELAY_DEPTH)
  `TPS_ASSERT(a_start_seen, clk, rst, (accept && start_req) |=> (seen == SW'(1)))
  `TPS_ASSERT(a_wp_moves, clk, rst, accept |=> (wp == $past(wp_next)))

endmodule

>>> rtl/tps_norm.sv
// ----------------------------------------------------------------------------
// Output normalization
// Multiplies the running sum by the Q16 gain, rounds half up, saturates to
// 16 bits and holds the result for the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tps_norm
  import tps_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SUM_W-1:0]    sum,
  input  logic [RECIP_W-1:0]         norm_recip,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SHAPED_W-1:0] shaped,
  output logic signed [SUM_W-1:0]    raw_sum
);

  localparam int PROD_W = SUM_W + RECIP_W + 1;

  localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(SHAPED_MAX);
  localparam logic signed [PROD_W-1:0] Q_MIN = PROD_W'(SHAPED_MIN);

  logic                     prod_valid;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  prod_sum;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] q;
  logic signed [SHAPED_W-1:0] q_sat;
  logic                     out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = !prod_valid || out_free;

  // Multiply stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (in_ready) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod     <= sum * $signed({1'b0, norm_recip});
      prod_sum <= sum;
    end
  end

  // Round half up, drop the fraction, saturate
  always_comb begin
    rnd = prod + PROD_W'(ROUND_HALF);
    q   = rnd >>> FRAC_BITS;
    if (q > Q_MAX) begin
      q_sat = SHAPED_W'(SHAPED_MAX);
    end else if (q < Q_MIN) begin
      q_sat = SHAPED_W'(SHAPED_MIN);
    end else begin
      q_sat = SHAPED_W'(q);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_free) begin
      shaped  <= q_sat;
      raw_sum <= prod_sum;
    end
  end

endmodule

>>> rtl/trapezoidal_pulse_shaper.sv
// ----------------------------------------------------------------------------
// Trapezoidal pulse shaper
// Takes one signed sample per clock while results are taken, and returns one
// result per sample: the running sum of x[n]-x[n-k]-x[n-k-l]+x[n-2k-l] and
// that sum scaled by a Q16 gain. The block accepts a new sample every cycle
// unless stalled. Each sample passes through the tap fetch, difference, sum,
// multiply and result registers, so up to five samples are in flight. A
// stalled result holds every stage behind it. The three delayed samples come
// from three copies of the delay memory, each with one read port, and the
// running sum is updated by one saturating add per cycle unless stalled. The
// delay memory needs no clearing after reset: history older than the samples
// seen since the last start request reads as zero. The user must write
// registers only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "trapezoidal_pulse_shaper_assert.svh"

module trapezoidal_pulse_shaper
  import tps_pkg::*;
#(
  parameter int MAX_RISE    = 512,
  parameter int MAX_FLAT    = 512,
  parameter int DELAY_DEPTH = 2048,
  parameter int SAMPLE_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tps_in_if.sink                samples,
  tps_out_if.source             results
);

  localparam int DIFF_W = SAMPLE_BITS + 2;

  localparam logic signed [SUM_W:0] S_MAX = (SUM_W + 1)'(SUM_MAX);
  localparam logic signed [SUM_W:0] S_MIN = (SUM_W + 1)'(SUM_MIN);

  logic [RISE_W-1:0]  rise_len;
  logic [FLAT_W-1:0]  flat_len;
  logic [RECIP_W-1:0] norm_recip;

  logic                                 tap_valid;
  logic                                 tap_ready;
  logic signed [SAMPLE_BITS-1:0]        cur;
  logic [NUM_TAPS-1:0][SAMPLE_BITS-1:0] taps;
  tps_stage_t                           tap_info;

  logic signed [DIFF_W-1:0] t0;
  logic signed [DIFF_W-1:0] t1;
  logic signed [DIFF_W-1:0] t2;
  logic signed [DIFF_W-1:0] d_next;
  logic signed [DIFF_W-1:0] d;
  logic                     d_valid;
  logic                     d_start;
  logic                     d_ready;

  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] running_sum_next;
  logic                    sum_valid;
  logic                    sum_ready;
  logic                    norm_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rise_len   <= RISE_LEN_RST;
      flat_len   <= FLAT_LEN_RST;
      norm_recip <= NORM_RECIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RISE_LEN:   rise_len   <= cfg_data[RISE_W-1:0];
        REG_FLAT_LEN:   flat_len   <= cfg_data[FLAT_W-1:0];
        REG_NORM_RECIP: norm_recip <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Delay line and tap fetch
  tps_delay_taps #(
    .MAX_RISE    (MAX_RISE),
    .MAX_FLAT    (MAX_FLAT),
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_taps (
    .clk       (clk),
    .rst       (rst),
    .rise_len  (rise_len),
    .flat_len  (flat_len),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .sample    (samples.sample),
    .start_req (samples.start_req),
    .out_valid (tap_valid),
    .out_ready (tap_ready),
    .cur       (cur),
    .taps      (taps),
    .info      (tap_info)
  );

  // Combine current and delayed samples; missing history counts as zero
  always_comb begin
    t0     = tap_info.tap_ok[0] ? DIFF_W'($signed(taps[0])) : '0;
    t1     = tap_info.tap_ok[1] ? DIFF_W'($signed(taps[1])) : '0;
    t2     = tap_info.tap_ok[2] ? DIFF_W'($signed(taps[2])) : '0;
    d_next = DIFF_W'(cur) - t0 - t1 + t2;
  end

  assign sum_ready = !sum_valid || norm_ready;
  assign d_ready   = !d_valid || sum_ready;
  assign tap_ready = d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (d_ready) begin
      d_valid <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_valid && d_ready) begin
      d       <= d_next;
      d_start <= tap_info.start;
    end
  end

  // Saturating running sum, cleared by a start request
  always_comb begin
    sum_wide = (d_start ? '0 : (SUM_W + 1)'(running_sum)) + (SUM_W + 1)'(d);
    if (sum_wide > S_MAX) begin
      running_sum_next = SUM_W'(SUM_MAX);
    end else if (sum_wide < S_MIN) begin
      running_sum_next = SUM_W'(SUM_MIN);
    end else begin
      running_sum_next = SUM_W'(sum_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      sum_valid   <= 1'b0;
    end else if (sum_ready) begin
      sum_valid <= d_valid;
      if (d_valid) begin
        running_sum <= running_sum_next;
      end
    end
  end

  // Gain, rounding and result register
  tps_norm u_norm (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (sum_valid),
    .in_ready   (norm_ready),
    .sum        (running_sum),
    .norm_recip (norm_recip),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .shaped     (results.shaped),
    .raw_sum    (results.raw_sum)
  );

  `TPS_ASSERT(a_start_sum, clk, rst, (d_valid && sum_ready && d_start) |=> (running_sum == SUM_W'($past(d))))
  `TPS_ASSERT(a_start_no_taps, clk, rst, (tap_valid && tap_info.start) |-> (tap_info.tap_ok == '0))
  `TPS_ASSERT_NEVER(a_sign_match, clk, rst, results.valid && (results.shaped < 0) && (results.raw_sum >= 0))
  `TPS_ASSERT(a_zero_sum, clk, rst, (results.valid && (results.raw_sum == '0)) |-> (results.shaped == '0))

endmodule

>>> verif/shaper_checker.sv
// ----------------------------------------------------------------------------
// Trapezoidal shaper checker
// Watches the configuration port and both channels, tracks its own copy of
// the delay history, running sum and gain settings, works out the result for
// every accepted sample and compares it with each accepted result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shaper_checker
  import tps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tps_in_if                     samples_mon,
  tps_out_if                    results_mon,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int HIST_DEPTH = 2048;
  localparam int RISE_CAP   = 512;
  localparam int FLAT_CAP   = 512;
  localparam int SAMPLE_W   = 14;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic signed [SHAPED_W-1:0] shaped;
    logic signed [SUM_W-1:0]    raw_sum;
  } shaper_out_t;

  // Shadow of the block state and settings
  logic signed [SAMPLE_W-1:0] hist [HIST_DEPTH];
  logic signed [SUM_W-1:0]    acc;
  int unsigned                stored;
  logic [10:0]                wr_idx;
  logic [RISE_W-1:0]          rise_q;
  logic [FLAT_W-1:0]          flat_q;
  logic [RECIP_W-1:0]         recip_q;

  shaper_out_t expected_q [$];
  int          n_results;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    n_results   = 0;
  end

  task automatic report(input string what);
    if (mismatches < REPORT_CAP) begin
      $display("[%0t] shaper check: %s", $time, what);
    end
    mismatches++;
  endtask

  // Sample taken dly requests ago, zero when older than the current waveform
  function automatic logic signed [SAMPLE_W-1:0] past_sample(int unsigned dly);
    if (dly == 0 || dly > stored) return '0;
    return hist[(wr_idx + HIST_DEPTH - dly) % HIST_DEPTH];
  endfunction

  // Advance the shadow state by one sample and return the result it gives
  function automatic shaper_out_t shape_sample(logic signed [SAMPLE_W-1:0] x,
                                               logic first);
    int unsigned k;
    int unsigned l;
    longint      diff;
    longint      total;
    longint      gain;
    longint      scaled;
    shaper_out_t res;
    k = rise_q;
    l = flat_q;
    if (k < 1) k = 1;
    if (k > RISE_CAP) k = RISE_CAP;
    if (l > FLAT_CAP) l = FLAT_CAP;
    if (first) begin
      acc    = '0;
      stored = 0;
    end
    diff = longint'(x) - longint'(past_sample(k)) - longint'(past_sample(k + l))
         + longint'(past_sample(2 * k + l));
    total = longint'(acc) + diff;
    if (total > SUM_MAX) total = SUM_MAX;
    if (total < SUM_MIN) total = SUM_MIN;
    acc = SUM_W'(total);
    hist[wr_idx] = x;
    wr_idx = wr_idx + 11'd1;
    if (stored < HIST_DEPTH) stored++;
    // Q16 gain, round half up, then clip to the output range
    gain   = recip_q;
    scaled = (total * gain + ROUND_HALF) >>> FRAC_BITS;
    if (scaled > SHAPED_MAX) scaled = SHAPED_MAX;
    if (scaled < SHAPED_MIN) scaled = SHAPED_MIN;
    res.shaped  = SHAPED_W'(scaled);
    res.raw_sum = acc;
    return res;
  endfunction

  always @(posedge clk) begin
    shaper_out_t want;
    if (rst) begin
      acc     = '0;
      stored  = 0;
      wr_idx  = '0;
      rise_q  = RISE_LEN_RST;
      flat_q  = FLAT_LEN_RST;
      recip_q = NORM_RECIP_RST;
      expected_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_RISE_LEN:   rise_q  = cfg_data[RISE_W-1:0];
          REG_FLAT_LEN:   flat_q  = cfg_data[FLAT_W-1:0];
          REG_NORM_RECIP: recip_q = cfg_data[RECIP_W-1:0];
          default: ;
        endcase
      end
      // Compare the accepted result with the oldest prediction
      if (results_mon.valid && results_mon.ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("result %0d with no request pending: shaped %0d raw_sum %0d",
                           n_results, results_mon.shaped, results_mon.raw_sum));
        end else begin
          want = expected_q.pop_front();
          if (results_mon.shaped !== want.shaped) begin
            report($sformatf("result %0d: shaped %0d, predicted %0d",
                             n_results, results_mon.shaped, want.shaped));
          end
          if (results_mon.raw_sum !== want.raw_sum) begin
            report($sformatf("result %0d: raw_sum %0d, predicted %0d",
                             n_results, results_mon.raw_sum, want.raw_sum));
          end
        end
        n_results++;
      end
      // Predict the result of each accepted request
      if (samples_mon.valid && samples_mon.ready) begin
        expected_q.push_back(shape_sample(samples_mon.sample, samples_mon.start_req));
      end
    end
    outstanding = expected_q.size();
  end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Trapezoidal shaper testbench
// Drives samples and register settings into the shaper with random gaps and
// result stalls, runs directed extremes then random pulse waveforms over
// several rise, flat and gain settings, and takes the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tps_pkg::*;

  localparam int                 RST_CYCLES     = 7;
  localparam int                 HOLD_CYCLES    = 300;
  localparam int                 WATCHDOG_LIMIT = 3000;
  localparam int                 END_SETTLE     = 20;
  localparam int                 PHASE_ITEMS    = 50;
  localparam int                 RISE_CAP       = 512;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tps_in_if #(.SAMPLE_BITS(14)) samples_ch ();
  tps_out_if                    results_ch ();

  int mismatches;
  int outstanding;
  int quiet_cycles;
  int cur_rise;
  int cur_flat;
  bit src_idle;
  bit snk_idle;
  bit stall_req;

  // Extremes, sign boundaries and alternating bit patterns
  int dir_vals [20] = '{8191, -8192, 0, -1, 1, 8191, 8191, -8192, -8192, 5461,
                        -5462, 0, 8191, -8192, -1, 4096, -4097, 0, 8191, -8192};

  trapezoidal_pulse_shaper DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_ch),
    .results   (results_ch)
  );

  shaper_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .samples_mon (samples_ch),
    .results_mon (results_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one sample after a random gap and hold it until accepted
  task automatic push_sample(input logic signed [13:0] x, input logic first);
    int gap;
    gap = src_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      samples_ch.valid <= 1'b0;
    end
    @(negedge clk);
    samples_ch.valid     <= 1'b1;
    samples_ch.sample    <= x;
    samples_ch.start_req <= first;
    do @(posedge clk); while (samples_ch.ready !== 1'b1);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
  endtask

  task automatic apply_setting(input int rise, input int flat, input int recip);
    write_reg(REG_RISE_LEN, rise);
    write_reg(REG_FLAT_LEN, flat);
    write_reg(REG_NORM_RECIP, recip);
    // Writes to the unused index must change nothing
    if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, $urandom_range(0, 131071));
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_rise  = rise;
    cur_flat  = flat;
  endtask

  function automatic logic signed [13:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 14'h2000;
      1:       return 14'h1FFF;
      2:       return '0;
      3:       return '1;
      4, 5, 6: return 14'($urandom);
      default: return 14'(int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // Detector-like pulse: baseline, one step of random height, small noise; sometimes raw random samples instead
  task automatic send_waveform(input int len);
    int base;
    int amp;
    int step_at;
    int v;
    bit raw;
    base    = int'($urandom_range(0, 400)) - 200;
    amp     = int'($urandom_range(0, 16383)) - 8192;
    step_at = $urandom_range(0, len - 1);
    raw     = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (raw) begin
        push_sample(rand_sample(), i == 0);
      end else begin
        v = base + ((i >= step_at) ? amp : 0) + int'($urandom_range(0, 16)) - 8;
        if (v > 8191) v = 8191;
        if (v < -8192) v = -8192;
        push_sample(14'(v), i == 0);
      end
    end
  endtask

  // Widest swing of the running sum at the largest rise and flat lengths
  task automatic send_extreme_pulse();
    for (int i = 0; i < 512; i++) push_sample(14'h2000, i == 0);
    for (int i = 0; i < 512; i++) push_sample(rand_sample(), 1'b0);
    for (int i = 0; i < 512; i++) push_sample(14'h1FFF, 1'b0);
    for (int i = 0; i < 64; i++) push_sample(rand_sample(), 1'b0);
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int k;
    int len_cap;
    int len;
    sent = 0;
    k = (cur_rise < 1) ? 1 : (cur_rise > RISE_CAP) ? RISE_CAP : cur_rise;
    len_cap = 2 * k + ((cur_flat > RISE_CAP) ? RISE_CAP : cur_flat) + 16;
    if (len_cap > 300) len_cap = 300;
    while (sent < n_items) begin
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      len = $urandom_range(1, len_cap);
      // Stop at the phase budget
      if (len > n_items - sent) len = n_items - sent;
      if ($urandom_range(0, 7) == 0) begin
        // Noise: random samples with stray start requests
        for (int i = 0; i < len; i++) push_sample(rand_sample(), $urandom_range(0, 15) == 0);
      end else begin
        send_waveform(len);
      end
      sent += len;
    end
  endtask

  // Result side: random stalls per result, plus one long hold on request
  initial begin
    int gap;
    results_ch.ready = 1'b0;
    forever begin
      if (stall_req) begin
        @(negedge clk);
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        stall_req = 1'b0;
      end
      gap = snk_idle ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
        @(negedge clk);
        results_ch.ready <= 1'b0;
      end
      @(negedge clk);
      results_ch.ready <= 1'b1;
      do @(posedge clk); while (results_ch.valid !== 1'b1);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (samples_ch.valid && samples_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int r;
    int k;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    samples_ch.valid     = 1'b0;
    samples_ch.sample    = '0;
    samples_ch.start_req = 1'b0;
    src_idle             = 1'b1;
    snk_idle             = 1'b1;
    stall_req            = 1'b0;
    quiet_cycles         = 0;
    cur_rise             = RISE_LEN_RST;
    cur_flat             = FLAT_LEN_RST;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed extremes under the reset settings, with a restart midway
    for (int i = 0; i < 20; i++) push_sample(14'(dir_vals[i]), i == 0 || i == 12);
    drain();

    // Shortest rise and no flat top at unity gain
    apply_setting(1, 0, 65536);
    run_phase(PHASE_ITEMS);
    drain();

    // Longest rise and flat top; stall results while samples keep coming
    apply_setting(512, 512, 128);
    stall_req = 1'b1;
    send_extreme_pulse();
    run_phase(PHASE_ITEMS);
    drain();

    // Rise of zero, flat top above the cap, largest gain
    apply_setting(0, 1023, 131071);
    run_phase(PHASE_ITEMS);
    drain();

    // Rise above the cap, zero gain
    apply_setting(1023, 600, 0);
    run_phase(PHASE_ITEMS);
    drain();

    // Random settings, mostly short rise with nominal gain
    repeat (5) begin
      r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(1, 48);
      k = (r < 1) ? 1 : (r > RISE_CAP) ? RISE_CAP : r;
      apply_setting(r,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 40),
                    ($urandom_range(0, 1) == 1) ? 65536 / k : $urandom_range(0, 131071));
      run_phase(PHASE_ITEMS);
      drain();
    end

    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> trapezoidal_pulse_shaper.f
+incdir+rtl
rtl/tps_pkg.sv
rtl/tps_in_if.sv
rtl/tps_out_if.sv
rtl/tps_tap_ram.sv
rtl/tps_delay_taps.sv
rtl/tps_norm.sv
rtl/trapezoidal_pulse_shaper.sv
verif/shaper_checker.sv
verif/tb.sv
